### sv/skf_pkg.sv
// shared types and constants for the scalar kalman height filter
// used by the interfaces, the controller, the datapath and the top level
`default_nettype none
package skf_pkg;

  localparam int HIST_DEPTH = 10;
  localparam int H_W        = 24;
  localparam int SPEED_W    = 25;
  localparam int VAR_W      = 32;
  localparam int GAIN_BITS  = 17;
  localparam int DIV_CNT_W  = $clog2(GAIN_BITS);
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAIN_BITS-1:0] G_ONE     = 17'h10000;
  localparam logic [VAR_W-1:0]     P_RESET   = 32'h0001_0000;
  localparam logic [VAR_W-1:0]     Q_RESET   = 32'd655;
  localparam logic [VAR_W-1:0]     R_RESET   = 32'h0001_0000;
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST = 5'(GAIN_BITS - 1);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_VAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PC,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture_h;
    logic load_pc;
    logic div_init;
    logic div_step;
    logic div_first;
    logic mul;
    logic commit;
    logic out_load;
    logic out_skip;
  } cmd_t;

endpackage
`default_nettype wire

### sv/skf_if.sv
// request channels of the kalman height filter
// depends on skf_pkg for field widths
`default_nettype none
interface skf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [skf_pkg::H_W-1:0]    height_sample;

  modport source (output valid, output op, output height_sample, input ready);
  modport sink   (input valid, input op, input height_sample, output ready);
endinterface

interface skf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              skipped;
  logic signed [skf_pkg::H_W-1:0]    filtered_height;
  logic signed [skf_pkg::SPEED_W-1:0] vertical_speed;

  modport source (output valid, output skipped, output filtered_height,
                  output vertical_speed, input ready);
  modport sink   (input valid, input skipped, input filtered_height,
                  input vertical_speed, output ready);
endinterface
`default_nettype wire

### sv/skf_ctrl.sv
// controller state machine: tick gating, update sequencing, output valid
// depends on skf_pkg
`default_nettype none
module skf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skf_pkg::cmd_t      cmd
);
  import skf_pkg::*;

  state_t                state_r, state_nxt;
  logic                  tick_r, tick_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  accept;

  assign out_valid = ovalid_r;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tick_r   <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    tick_nxt   = tick_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_ready;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = !ovalid_r || out_ready;
        if (accept) begin
          if (in_op == OP_TICK) begin
            tick_nxt = 1'b0;
          end else if (tick_r) begin
            cmd.out_load = 1'b1;
            cmd.out_skip = 1'b1;
            ovalid_nxt   = 1'b1;
          end else begin
            tick_nxt      = 1'b1;
            cmd.capture_h = 1'b1;
            state_nxt     = S_PC;
          end
        end
      end
      S_PC: begin
        cmd.load_pc = 1'b1;
        state_nxt   = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = DIV_FIRST;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == DIV_FIRST);
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        ovalid_nxt   = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/skf_dp.sv
// datapath: variances, covariance, serial gain divider, multipliers,
// estimate, history window and result register; depends on skf_pkg
`default_nettype none
module skf_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire skf_pkg::cmd_t                  cmd,
  input  wire logic                           cfg_we,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [skf_pkg::VAR_W-1:0]      cfg_wdata,
  input  wire logic signed [skf_pkg::H_W-1:0] h_in,
  output logic                                skipped,
  output logic signed [skf_pkg::H_W-1:0]      filtered_height,
  output logic signed [skf_pkg::SPEED_W-1:0]  vertical_speed
);
  import skf_pkg::*;

  localparam logic signed [H_W+3:0] EST_MAX = 28'sd8388607;
  localparam logic signed [H_W+3:0] EST_MIN = -28'sd8388608;

  logic [VAR_W-1:0]            qvar_r, rvar_r, p_r, pc_r;
  logic [VAR_W:0]              den_r, rem_r;
  logic                        den_zero_r;
  logic [GAIN_BITS-1:0]        q_r;
  logic signed [H_W-1:0]       h_r, est_r;
  logic signed [H_W-1:0]       hist_r [HIST_DEPTH];
  logic [48:0]                 pmul_r;
  logic signed [42:0]          emul_r;
  logic                        skip_r;
  logic signed [H_W-1:0]       fh_r;
  logic signed [SPEED_W-1:0]   vs_r;

  logic [VAR_W:0]              pc_sum, den_sum;
  logic [VAR_W-1:0]            pc_sat;
  logic [VAR_W+1:0]            rem_sh, rem_sub;
  logic                        ge;
  logic [GAIN_BITS-1:0]        g, g_comp;
  logic signed [GAIN_BITS:0]   g_s;
  logic signed [H_W:0]         diff;
  logic signed [42:0]          rnd;
  logic signed [H_W+3:0]       est_sum;
  logic signed [H_W-1:0]       est_new;

  assign pc_sum  = {1'b0, p_r} + {1'b0, qvar_r};
  assign pc_sat  = pc_sum[VAR_W] ? '1 : pc_sum[VAR_W-1:0];
  assign den_sum = {1'b0, pc_r} + {1'b0, rvar_r};

  assign rem_sh  = {rem_r, (cmd.div_first ? pc_r[0] : 1'b0)};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  assign g       = den_zero_r ? G_ONE : q_r;
  assign g_comp  = G_ONE - g;
  assign g_s     = $signed({1'b0, g});
  assign diff    = {h_r[H_W-1], h_r} - {est_r[H_W-1], est_r};

  assign rnd     = emul_r + 43'sd32768;
  assign est_sum = {{4{est_r[H_W-1]}}, est_r} + {rnd[42], rnd[42:16]};

  always_comb begin
    if (est_sum > EST_MAX) begin
      est_new = EST_MAX[H_W-1:0];
    end else if (est_sum < EST_MIN) begin
      est_new = EST_MIN[H_W-1:0];
    end else begin
      est_new = est_sum[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qvar_r <= Q_RESET;
      rvar_r <= R_RESET;
      p_r    <= P_RESET;
      est_r  <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_idx == CFG_PROC_VAR) begin
        qvar_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == CFG_MEAS_VAR) begin
        rvar_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        p_r   <= pmul_r[47:16];
        est_r <= est_new;
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          hist_r[i] <= hist_r[i+1];
        end
        hist_r[HIST_DEPTH-1] <= est_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_h) begin
      h_r <= h_in;
    end
    if (cmd.load_pc) begin
      pc_r <= pc_sat;
    end
    if (cmd.div_init) begin
      den_r      <= den_sum;
      den_zero_r <= (den_sum == '0);
      rem_r      <= {2'b00, pc_r[VAR_W-1:1]};
      q_r        <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[VAR_W:0] : rem_sh[VAR_W:0];
      q_r   <= {q_r[GAIN_BITS-2:0], ge};
    end
    if (cmd.mul) begin
      pmul_r <= {32'd0, g_comp} * {17'd0, pc_r};
      emul_r <= g_s * diff;
    end
    if (cmd.out_load) begin
      skip_r <= cmd.out_skip;
      fh_r   <= est_r;
      vs_r   <= {hist_r[HIST_DEPTH-1][H_W-1], hist_r[HIST_DEPTH-1]}
              - {hist_r[0][H_W-1], hist_r[0]};
    end
  end

  assign skipped         = skip_r;
  assign filtered_height = fh_r;
  assign vertical_speed  = vs_r;

endmodule
`default_nettype wire

### sv/scalar_kalman_height_speed.sv
// scalar kalman height filter with vertical speed, one update per timer tick
// a tick gives no result; a skipped sample is shown in the cycle after accept;
// an update runs PC, DINIT, the 17-step gain divider in DIV, then MUL, FIN and OUT
// one item at a time: next request is taken once the result register is free
// synchronous active-low reset restores variances, covariance 1.0, zero estimate
// and zero history; depends on skf_pkg, skf_if, skf_ctrl and skf_dp
`default_nettype none
module scalar_kalman_height_speed (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  skf_in_if.sink                              in_ch,
  skf_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [skf_pkg::VAR_W-1:0]      cfg_wdata
);
  import skf_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  skf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .h_in            (in_ch.height_sample),
    .skipped         (out_ch.skipped),
    .filtered_height (out_ch.filtered_height),
    .vertical_speed  (out_ch.vertical_speed)
  );

endmodule
`default_nettype wire
